// ----- src/fvi_pkg.sv -----
// ----------------------------------------------------------------------------
// Face velocity interpolator package
// Shared widths, command and status codes, register indexes and the sideband
// record that travels down the pipeline next to the quotients.
// ----------------------------------------------------------------------------
package fvi_pkg;

	localparam int DATA_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF  = 16;

	localparam int VAL_W     = 32;
	localparam int COEF_W    = 31;
	localparam int CMD_W     = 2;
	localparam int STAT_W    = 2;
	localparam int CFG_IDX_W = 2;
	localparam int K_W       = 62;
	localparam int NUM_W     = 34;

	typedef enum logic [CMD_W-1:0] {
		CMD_RHIE_CHOW = 2'd0,
		CMD_CORRECT   = 2'd1,
		CMD_AVERAGE   = 2'd2,
		CMD_SPARE     = 2'd3
	} cmd_t;

	localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
	localparam logic [STAT_W-1:0] STAT_ZERO_COEF = 2'd1;
	localparam logic [STAT_W-1:0] STAT_SAT       = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CELL_WIDTH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CELL_HEIGHT = 2'd2;

	typedef struct packed {
		logic                    zero;
		logic                    use_term;
		logic signed [VAL_W-1:0] base;
		logic [K_W-1:0]          k;
	} side_t;

endpackage

// ----- src/fvi_front.sv -----
// ----------------------------------------------------------------------------
// Front stage
// Forms the two pressure numerators, their magnitudes, the base value and the
// scale factor dt*A, and registers them as the first pipeline stage.
// ----------------------------------------------------------------------------
module fvi_front #(
	parameter int FRAC_BITS = fvi_pkg::FRAC_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 en,
	input  logic                                 in_valid,
	input  logic [fvi_pkg::CMD_W-1:0]            cmd,
	input  logic                                 orientation,
	input  logic signed [fvi_pkg::VAL_W-1:0]     vel_first,
	input  logic signed [fvi_pkg::VAL_W-1:0]     vel_second,
	input  logic signed [fvi_pkg::VAL_W-1:0]     p_first,
	input  logic signed [fvi_pkg::VAL_W-1:0]     p_second,
	input  logic [fvi_pkg::COEF_W-1:0]           coef_first,
	input  logic [fvi_pkg::COEF_W-1:0]           coef_second,
	input  logic signed [fvi_pkg::VAL_W-1:0]     pface_back,
	input  logic signed [fvi_pkg::VAL_W-1:0]     pface_mid,
	input  logic signed [fvi_pkg::VAL_W-1:0]     pface_far,
	input  logic [fvi_pkg::COEF_W-1:0]           time_step,
	input  logic [fvi_pkg::COEF_W-1:0]           cell_width,
	input  logic [fvi_pkg::COEF_W-1:0]           cell_height,
	output logic                                 valid_s1,
	output fvi_pkg::side_t                       side_s1,
	output logic [fvi_pkg::NUM_W-1:0]            mag_first_s1,
	output logic                                 neg_first_s1,
	output logic [fvi_pkg::NUM_W-1:0]            mag_second_s1,
	output logic                                 neg_second_s1,
	output logic [fvi_pkg::COEF_W-1:0]           den_first_s1,
	output logic [fvi_pkg::COEF_W-1:0]           den_second_s1
);
	import fvi_pkg::*;

	logic signed [NUM_W:0]   dp;
	logic signed [NUM_W:0]   num_first;
	logic signed [NUM_W:0]   num_second;
	logic signed [VAL_W:0]   vel_sum;
	logic signed [VAL_W:0]   vel_adj;
	logic signed [VAL_W-1:0] avg;
	logic                    press_cmd;
	side_t                   side;
	logic [COEF_W-1:0]       area;
	logic [K_W-1:0]          dt_area;

	always_comb begin
		press_cmd = (cmd == CMD_RHIE_CHOW) || (cmd == CMD_CORRECT);
		dp = (NUM_W+1)'(p_second) - (NUM_W+1)'(p_first);
		if (cmd == CMD_CORRECT) begin
			num_first  = -dp;
			num_second = -dp;
		end else begin
			num_first  = (NUM_W+1)'(pface_mid) - (NUM_W+1)'(pface_back) - dp;
			num_second = (NUM_W+1)'(pface_far) - (NUM_W+1)'(pface_mid) - dp;
		end
		// Halving rounds toward zero, so a negative odd sum is nudged up first.
		vel_sum = (VAL_W+1)'(vel_first) + (VAL_W+1)'(vel_second);
		vel_adj = vel_sum + (VAL_W+1)'({1'b0, vel_sum[VAL_W]});
		avg     = VAL_W'(vel_adj >>> 1);
		area    = orientation ? cell_width : cell_height;
		dt_area = K_W'(time_step) * K_W'(area);
		side.zero     = press_cmd && ((coef_first == '0) || (coef_second == '0));
		side.use_term = press_cmd && !side.zero;
		side.base     = (cmd == CMD_CORRECT) ? vel_first : avg;
		side.k        = dt_area >> FRAC_BITS;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1       <= side;
			mag_first_s1  <= num_first[NUM_W] ? NUM_W'(-num_first) : num_first[NUM_W-1:0];
			neg_first_s1  <= num_first[NUM_W];
			mag_second_s1 <= num_second[NUM_W] ? NUM_W'(-num_second) : num_second[NUM_W-1:0];
			neg_second_s1 <= num_second[NUM_W];
			den_first_s1  <= coef_first;
			den_second_s1 <= coef_second;
		end
	end

endmodule

// ----- src/fvi_divider.sv -----
// ----------------------------------------------------------------------------
// Pipelined fixed-point divider
// Restoring division of (magnitude << FRAC_BITS) by a 31-bit coefficient, one
// quotient bit per register stage, with the magnitude clamp on the way out.
// ----------------------------------------------------------------------------
module fvi_divider #(
	parameter int  FRAC_BITS = fvi_pkg::FRAC_BITS_DEF,
	localparam int NB        = fvi_pkg::NUM_W + FRAC_BITS,
	localparam int QW        = (NB > 61) ? 62 : NB
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic [fvi_pkg::NUM_W-1:0]     mag,
	input  logic [fvi_pkg::COEF_W-1:0]    den,
	output logic [QW-1:0]                 quo,
	output logic                          sat
);
	import fvi_pkg::*;

	logic [COEF_W-1:0] rem_r [1:NB-1];
	logic [NUM_W-1:0]  mag_r [1:NB-1];
	logic [COEF_W-1:0] den_r [1:NB-1];
	logic [NB-1:0]     q_r   [1:NB];

	for (genvar j = 0; j < NB; j++) begin : g_step
		localparam int BI = NB - 1 - j;
		logic [COEF_W-1:0] rem_p;
		logic [COEF_W-1:0] den_p;
		logic [NUM_W-1:0]  mag_p;
		logic [NB-1:0]     q_p;
		logic              bit_in;
		logic [COEF_W:0]   trial;
		logic              ge;

		if (j == 0) begin : g_first
			assign rem_p = '0;
			assign den_p = den;
			assign mag_p = mag;
			assign q_p   = '0;
		end else begin : g_next
			assign rem_p = rem_r[j];
			assign den_p = den_r[j];
			assign mag_p = mag_r[j];
			assign q_p   = q_r[j];
		end

		if (BI >= FRAC_BITS) begin : g_bit
			assign bit_in = mag_p[BI-FRAC_BITS];
		end else begin : g_zero
			assign bit_in = 1'b0;
		end

		assign trial = {rem_p, bit_in};
		assign ge    = trial >= {1'b0, den_p};

		always_ff @(posedge clk) begin
			if (en) begin
				q_r[j+1] <= {q_p[NB-2:0], ge};
			end
		end

		if (j < NB - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					rem_r[j+1] <= ge ? COEF_W'(trial - {1'b0, den_p}) : trial[COEF_W-1:0];
					mag_r[j+1] <= mag_p;
					den_r[j+1] <= den_p;
				end
			end
		end
	end

	// The quotient only grows bit by bit, so clamping the final value matches
	// stopping at the first step that passes the cap.
	if (NB > 61) begin : g_clamp
		localparam logic [NB-1:0] CAP = NB'(1) << 61;
		assign sat = q_r[NB] > CAP;
		assign quo = sat ? QW'(CAP) : q_r[NB][QW-1:0];
	end else begin : g_plain
		assign sat = 1'b0;
		assign quo = q_r[NB];
	end

endmodule

// ----- src/fvi_scale.sv -----
// ----------------------------------------------------------------------------
// Pressure term scaling
// Adds the two signed quotients, multiplies the magnitude by dt*A in four
// partial products of at most 32x32 bits, shifts, clamps and restores the sign.
// ----------------------------------------------------------------------------
module fvi_scale #(
	parameter int FRAC_BITS = fvi_pkg::FRAC_BITS_DEF,
	parameter int QW        = fvi_pkg::NUM_W + fvi_pkg::FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 valid_in,
	input  fvi_pkg::side_t       side_in,
	input  logic [QW-1:0]        quo_first,
	input  logic                 neg_first,
	input  logic [QW-1:0]        quo_second,
	input  logic                 neg_second,
	input  logic                 div_sat,
	output logic                 valid_out,
	output fvi_pkg::side_t       side_out,
	output logic signed [62:0]   term,
	output logic                 term_sat
);
	import fvi_pkg::*;

	localparam int SUM_W = QW + 2;
	localparam logic [127:0] CAP = 128'(1) << 61;

	logic signed [SUM_W-1:0] sq_first;
	logic signed [SUM_W-1:0] sq_second;
	logic signed [SUM_W-1:0] qsum;
	logic [127:0]            prod;
	logic [127:0]            shifted;
	logic                    clamp;
	logic [61:0]             tmag;

	logic [3:0]    valid_q;
	side_t         side_a_s1, side_b_s2, side_c_s3;
	logic          sat_a_s1, sat_b_s2, sat_c_s3;
	logic          neg_a_s1, neg_b_s2, neg_c_s3;
	logic [63:0]   mag_a_s1;
	logic [63:0]   p00_s2, p01_s2, p10_s2, p11_s2;
	logic [127:0]  prod_s3;

	always_comb begin
		sq_first  = neg_first ? -SUM_W'(quo_first) : SUM_W'(quo_first);
		sq_second = neg_second ? -SUM_W'(quo_second) : SUM_W'(quo_second);
		qsum      = sq_first + sq_second;
		prod      = 128'(p00_s2) + (128'(p01_s2) << 32) + (128'(p10_s2) << 32)
			+ (128'(p11_s2) << 64);
		shifted   = prod_s3 >> (FRAC_BITS + 1);
		clamp     = shifted > CAP;
		tmag      = clamp ? 62'(CAP) : shifted[61:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (en) begin
			valid_q <= {valid_q[2:0], valid_in};
		end
	end

	assign valid_out = valid_q[3];

	always_ff @(posedge clk) begin
		if (en) begin
			side_a_s1 <= side_in;
			sat_a_s1  <= div_sat;
			neg_a_s1  <= qsum[SUM_W-1];
			mag_a_s1  <= 64'(qsum[SUM_W-1] ? -qsum : qsum);

			side_b_s2 <= side_a_s1;
			sat_b_s2  <= sat_a_s1;
			neg_b_s2  <= neg_a_s1;
			p00_s2    <= 64'(mag_a_s1[31:0]) * 64'(side_a_s1.k[31:0]);
			p01_s2    <= 64'(mag_a_s1[31:0]) * 64'(side_a_s1.k[61:32]);
			p10_s2    <= 64'(mag_a_s1[63:32]) * 64'(side_a_s1.k[31:0]);
			p11_s2    <= 64'(mag_a_s1[63:32]) * 64'(side_a_s1.k[61:32]);

			side_c_s3 <= side_b_s2;
			sat_c_s3  <= sat_b_s2;
			neg_c_s3  <= neg_b_s2;
			prod_s3   <= prod;

			// The term only exists for a pressure command with usable coefficients.
			side_out  <= side_c_s3;
			term_sat  <= side_c_s3.use_term && (sat_c_s3 || clamp);
			if (!side_c_s3.use_term) begin
				term <= '0;
			end else if (neg_c_s3) begin
				term <= -63'(tmag);
			end else begin
				term <= 63'(tmag);
			end
		end
	end

endmodule

// ----- src/fvi_output.sv -----
// ----------------------------------------------------------------------------
// Output stage
// Adds the pressure term to the base value, saturates to the output range
// and forms the status code. Its registers drive the output channel.
// ----------------------------------------------------------------------------
module fvi_output #(
	parameter int DATA_WIDTH = fvi_pkg::DATA_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic                                valid_in,
	input  fvi_pkg::side_t                      side_in,
	input  logic signed [62:0]                  term,
	input  logic                                term_sat,
	output logic                                out_valid,
	output logic signed [fvi_pkg::VAL_W-1:0]    face_velocity,
	output logic [fvi_pkg::STAT_W-1:0]          status
);
	import fvi_pkg::*;

	localparam int OUT_BITS = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
	localparam logic signed [63:0] OUT_HI = 64'((65'(1) << (OUT_BITS - 1)) - 65'(1));
	localparam logic signed [63:0] OUT_LO = -OUT_HI - 64'sd1;

	logic signed [63:0] sum;
	logic signed [63:0] clamped;
	logic               sat;

	always_comb begin
		sum = 64'(side_in.base) + 64'(term);
		if (sum > OUT_HI) begin
			clamped = OUT_HI;
			sat     = 1'b1;
		end else if (sum < OUT_LO) begin
			clamped = OUT_LO;
			sat     = 1'b1;
		end else begin
			clamped = sum;
			sat     = term_sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			face_velocity <= VAL_W'(clamped);
			if (side_in.zero) begin
				status <= STAT_ZERO_COEF;
			end else if (sat) begin
				status <= STAT_SAT;
			end else begin
				status <= STAT_OK;
			end
		end
	end

endmodule

// ----- src/face_velocity_interpolator.sv -----
// ----------------------------------------------------------------------------
// Face velocity interpolator
// Rhie-Chow interpolation, pressure-correction update or plain average of one
// interior face per transfer, in signed fixed point with saturation.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake             Content
//  in       in         in_valid / in_stall   cmd, orientation, cells, faces
//  out      out        out_valid / out_stall face_velocity, status
//  cfg      in         cfg_write             cfg_index, cfg_data
//
// One face enters per cycle while the output is not stalled. The quotients
// come from two restoring dividers, one bit a stage.
// Reset clears the valid bits and loads dt, dx and dy with 1.0.
// When the output holds a transfer that is stalled, the whole pipeline holds
// and in_stall is raised in the same cycle.
// ----------------------------------------------------------------------------
module face_velocity_interpolator #(
	parameter int DATA_WIDTH = fvi_pkg::DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = fvi_pkg::FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [fvi_pkg::CMD_W-1:0]           cmd,
	input  logic                                orientation,
	input  logic signed [fvi_pkg::VAL_W-1:0]    vel_first,
	input  logic signed [fvi_pkg::VAL_W-1:0]    vel_second,
	input  logic signed [fvi_pkg::VAL_W-1:0]    p_first,
	input  logic signed [fvi_pkg::VAL_W-1:0]    p_second,
	input  logic [fvi_pkg::COEF_W-1:0]          coef_first,
	input  logic [fvi_pkg::COEF_W-1:0]          coef_second,
	input  logic signed [fvi_pkg::VAL_W-1:0]    pface_back,
	input  logic signed [fvi_pkg::VAL_W-1:0]    pface_mid,
	input  logic signed [fvi_pkg::VAL_W-1:0]    pface_far,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [fvi_pkg::VAL_W-1:0]    face_velocity,
	output logic [fvi_pkg::STAT_W-1:0]          status,
	input  logic                                cfg_write,
	input  logic [fvi_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [fvi_pkg::COEF_W-1:0]          cfg_data
);
	import fvi_pkg::*;

	localparam int NB = NUM_W + FRAC_BITS;
	localparam int QW = (NB > 61) ? 62 : NB;
	localparam logic [COEF_W-1:0] ONE = COEF_W'(1) << FRAC_BITS;

	logic              adv;
	logic [COEF_W-1:0] time_step_q, cell_width_q, cell_height_q;

	logic              valid_s1;
	side_t             side_s1;
	logic [NUM_W-1:0]  mag_first_s1, mag_second_s1;
	logic              neg_first_s1, neg_second_s1;
	logic [COEF_W-1:0] den_first_s1, den_second_s1;

	logic              valid_d [1:NB];
	side_t             side_d  [1:NB];
	logic              neg1_d  [1:NB];
	logic              neg2_d  [1:NB];

	logic [QW-1:0]     quo_first, quo_second;
	logic              sat_first, sat_second;

	logic              valid_sc;
	side_t             side_sc;
	logic signed [62:0] term_sc;
	logic              sat_sc;

	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_step_q   <= ONE;
			cell_width_q  <= ONE;
			cell_height_q <= ONE;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_TIME_STEP:   time_step_q   <= cfg_data;
				CFG_CELL_WIDTH:  cell_width_q  <= cfg_data;
				CFG_CELL_HEIGHT: cell_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	fvi_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (adv),
		.in_valid      (in_valid),
		.cmd           (cmd),
		.orientation   (orientation),
		.vel_first     (vel_first),
		.vel_second    (vel_second),
		.p_first       (p_first),
		.p_second      (p_second),
		.coef_first    (coef_first),
		.coef_second   (coef_second),
		.pface_back    (pface_back),
		.pface_mid     (pface_mid),
		.pface_far     (pface_far),
		.time_step     (time_step_q),
		.cell_width    (cell_width_q),
		.cell_height   (cell_height_q),
		.valid_s1      (valid_s1),
		.side_s1       (side_s1),
		.mag_first_s1  (mag_first_s1),
		.neg_first_s1  (neg_first_s1),
		.mag_second_s1 (mag_second_s1),
		.neg_second_s1 (neg_second_s1),
		.den_first_s1  (den_first_s1),
		.den_second_s1 (den_second_s1)
	);

	fvi_divider #(.FRAC_BITS(FRAC_BITS)) u_div_first (
		.clk (clk),
		.en  (adv),
		.mag (mag_first_s1),
		.den (den_first_s1),
		.quo (quo_first),
		.sat (sat_first)
	);

	fvi_divider #(.FRAC_BITS(FRAC_BITS)) u_div_second (
		.clk (clk),
		.en  (adv),
		.mag (mag_second_s1),
		.den (den_second_s1),
		.quo (quo_second),
		.sat (sat_second)
	);

	// Sideband delay line matching the divider latency.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= NB; i++) begin
				valid_d[i] <= 1'b0;
			end
		end else if (adv) begin
			valid_d[1] <= valid_s1;
			for (int i = 2; i <= NB; i++) begin
				valid_d[i] <= valid_d[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_d[1] <= side_s1;
			neg1_d[1] <= neg_first_s1;
			neg2_d[1] <= neg_second_s1;
			for (int i = 2; i <= NB; i++) begin
				side_d[i] <= side_d[i-1];
				neg1_d[i] <= neg1_d[i-1];
				neg2_d[i] <= neg2_d[i-1];
			end
		end
	end

	fvi_scale #(.FRAC_BITS(FRAC_BITS), .QW(QW)) u_scale (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (adv),
		.valid_in   (valid_d[NB]),
		.side_in    (side_d[NB]),
		.quo_first  (quo_first),
		.neg_first  (neg1_d[NB]),
		.quo_second (quo_second),
		.neg_second (neg2_d[NB]),
		.div_sat    (sat_first || sat_second),
		.valid_out  (valid_sc),
		.side_out   (side_sc),
		.term       (term_sc),
		.term_sat   (sat_sc)
	);

	fvi_output #(.DATA_WIDTH(DATA_WIDTH)) u_output (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (adv),
		.valid_in      (valid_sc),
		.side_in       (side_sc),
		.term          (term_sc),
		.term_sat      (sat_sc),
		.out_valid     (out_valid),
		.face_velocity (face_velocity),
		.status        (status)
	);

endmodule

// ----- src/fvi_checker.sv -----
// ----------------------------------------------------------------------------
// Face velocity interpolator port checker
// Watches the ports of the top level over time and is bound to it below.
// ----------------------------------------------------------------------------
module fvi_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_stall,
	input logic                                out_valid,
	input logic                                out_stall,
	input logic signed [fvi_pkg::VAL_W-1:0]    face_velocity,
	input logic [fvi_pkg::STAT_W-1:0]          status
);
	import fvi_pkg::*;

	// A stalled result stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("stalled result transfer was withdrawn");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(face_velocity) && $stable(status))
		else $error("stalled result changed");

	// The input is held back exactly when the output is blocked.
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall == (out_valid && out_stall))
		else $error("input stall does not follow output back-pressure");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == STAT_OK) || (status == STAT_ZERO_COEF)
			|| (status == STAT_SAT))
		else $error("unknown status code on result");

endmodule

bind face_velocity_interpolator fvi_checker u_fvi_checker (.*);

// ----- tb/tb_face_velocity_interpolator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Face velocity interpolator testbench
// Sends faces through the valid/stall input channel and checks each result
// against a local predictor of the Rhie-Chow, correction and average paths,
// under several register settings and with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_face_velocity_interpolator;

	import fvi_pkg::*;

	localparam int  LATENCY    = 56;
	localparam int  WATCHDOG   = 5000;
	localparam longint OUT_MAX = 64'sd2147483647;
	localparam longint OUT_MIN = -64'sd2147483648;
	localparam logic [63:0] MAG_CAP = 64'd1 << 61;

	typedef struct {
		cmd_t              op;
		logic              orient;
		logic signed [31:0] v1, v2, p1, p2, pb, pm, pf;
		logic [30:0]       a1, a2;
	} face_t;

	typedef struct {
		logic signed [31:0] vel;
		logic [1:0]         st;
	} face_result_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [1:0]         cmd = '0;
	logic               orientation = 1'b0;
	logic signed [31:0] vel_first = '0, vel_second = '0, p_first = '0, p_second = '0;
	logic [30:0]        coef_first = '0, coef_second = '0;
	logic signed [31:0] pface_back = '0, pface_mid = '0, pface_far = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic signed [31:0] face_velocity;
	logic [1:0]         status;
	logic               cfg_write = 1'b0;
	logic [1:0]         cfg_index = '0;
	logic [30:0]        cfg_data = '0;

	// Register copies used by the predictor.
	logic [30:0] dt_reg = 31'd65536, dx_reg = 31'd65536, dy_reg = 31'd65536;

	face_result_t pending_faces[$];
	int errors = 0;
	int sent = 0, checked = 0, n_zero = 0, n_sat = 0, n_writes = 0;
	int send_idle_pct = 0, recv_stall_pct = 0;
	int quiet_cycles = 0;

	face_velocity_interpolator i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.cmd(cmd), .orientation(orientation),
		.vel_first(vel_first), .vel_second(vel_second),
		.p_first(p_first), .p_second(p_second),
		.coef_first(coef_first), .coef_second(coef_second),
		.pface_back(pface_back), .pface_mid(pface_mid), .pface_far(pface_far),
		.out_valid(out_valid), .out_stall(out_stall),
		.face_velocity(face_velocity), .status(status),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// (num << 16) / den with truncation toward zero; never reaches the cap here.
	function automatic longint fixed_quotient(longint num, longint unsigned den);
		longint unsigned mag;
		longint unsigned q;
		mag = (num < 0) ? longint'(-num) : longint'(num);
		q = (mag << 16) / den;
		return (num < 0) ? -longint'(q) : longint'(q);
	endfunction

	function automatic longint scaled_term(longint s, logic [30:0] area, ref bit sat);
		logic [63:0]  k;
		logic [63:0]  mag;
		logic [127:0] prod;
		k = ({33'd0, dt_reg} * {33'd0, area}) >> 16;
		mag = (s < 0) ? 64'(-s) : 64'(s);
		prod = ({64'd0, mag} * {64'd0, k}) >> 17;
		if (prod > {64'd0, MAG_CAP}) begin
			prod = {64'd0, MAG_CAP};
			sat = 1'b1;
		end
		return (s < 0) ? -longint'(prod[63:0]) : longint'(prod[63:0]);
	endfunction

	function automatic face_result_t predict_face(face_t f);
		face_result_t r;
		longint avg, res, d;
		bit sat, zero;
		logic [30:0] area;
		sat = 1'b0;
		zero = 1'b0;
		area = f.orient ? dx_reg : dy_reg;
		avg = (longint'(f.v1) + longint'(f.v2)) / 2;
		if (f.op == CMD_RHIE_CHOW || f.op == CMD_CORRECT)
			zero = (f.a1 == 0) || (f.a2 == 0);
		if (f.op == CMD_RHIE_CHOW) begin
			if (zero) res = avg;
			else begin
				d = longint'(f.p2) - longint'(f.p1);
				res = avg + scaled_term(
					fixed_quotient(longint'(f.pm) - f.pb - d, f.a1) +
					fixed_quotient(longint'(f.pf) - f.pm - d, f.a2), area, sat);
			end
		end else if (f.op == CMD_CORRECT) begin
			if (zero) res = f.v1;
			else begin
				d = longint'(f.p1) - longint'(f.p2);
				res = longint'(f.v1) + scaled_term(
					fixed_quotient(d, f.a1) + fixed_quotient(d, f.a2), area, sat);
			end
		end else begin
			res = avg;
		end
		if (res > OUT_MAX) begin res = OUT_MAX; sat = 1'b1; end
		if (res < OUT_MIN) begin res = OUT_MIN; sat = 1'b1; end
		r.vel = res[31:0];
		r.st = zero ? STAT_ZERO_COEF : (sat ? STAT_SAT : STAT_OK);
		return r;
	endfunction

	// Sends one face and waits for its transfer; a random gap may follow.
	task automatic send_face(face_t f);
		face_result_t r;
		in_valid    <= 1'b1;
		cmd         <= f.op;
		orientation <= f.orient;
		vel_first   <= f.v1;
		vel_second  <= f.v2;
		p_first     <= f.p1;
		p_second    <= f.p2;
		coef_first  <= f.a1;
		coef_second <= f.a2;
		pface_back  <= f.pb;
		pface_mid   <= f.pm;
		pface_far   <= f.pf;
		do @(posedge clk); while (in_stall);
		r = predict_face(f);
		pending_faces.push_back(r);
		sent++;
		if (r.st == STAT_ZERO_COEF) n_zero++;
		if (r.st == STAT_SAT) n_sat++;
		// Each idle cycle is drawn on its own, so the idle share matches the percentage.
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_faces.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [30:0] val);
		drain_results();
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_write <= 1'b0;
		case (idx)
			CFG_TIME_STEP:   dt_reg = val;
			CFG_CELL_WIDTH:  dx_reg = val;
			CFG_CELL_HEIGHT: dy_reg = val;
			default: ;
		endcase
		n_writes++;
	endtask

	// Signed value of random magnitude, so small and large numbers both appear.
	function automatic logic signed [31:0] rand_value();
		logic [31:0] x;
		x = $urandom();
		if ($urandom_range(3) == 0) return x;
		return $signed(x) >>> $urandom_range(0, 31);
	endfunction

	function automatic logic [30:0] rand_coef();
		logic [30:0] c;
		c = 31'($urandom()) >> $urandom_range(0, 30);
		if ($urandom_range(19) == 0) c = '0;
		else if (c == 0) c = 31'd1;
		return c;
	endfunction

	function automatic face_t rand_face();
		face_t f;
		f.op     = cmd_t'($urandom_range(0, 3));
		f.orient = $urandom_range(1);
		f.v1 = rand_value();
		f.v2 = rand_value();
		f.p1 = rand_value();
		f.p2 = rand_value();
		f.pb = rand_value();
		f.pm = rand_value();
		f.pf = rand_value();
		f.a1 = rand_coef();
		f.a2 = rand_coef();
		return f;
	endfunction

	function automatic face_t make_face(cmd_t op, logic o, logic signed [31:0] v1,
			logic signed [31:0] v2, logic signed [31:0] p1, logic signed [31:0] p2,
			logic [30:0] a1, logic [30:0] a2);
		face_t f;
		f.op = op; f.orient = o; f.v1 = v1; f.v2 = v2; f.p1 = p1; f.p2 = p2;
		f.a1 = a1; f.a2 = a2;
		f.pb = 32'sh8000_0000; f.pm = 32'sh0001_0000; f.pf = 32'sh7FFF_FFFF;
		return f;
	endfunction

	task automatic test_directed();
		localparam logic signed [31:0] SMAX = 32'sh7FFF_FFFF;
		localparam logic signed [31:0] SMIN = 32'sh8000_0000;
		localparam logic [30:0] CMAX = 31'h7FFF_FFFF;
		face_t f;
		send_face(make_face(CMD_AVERAGE, 0, SMAX, SMAX, 0, 0, 1, 1));
		send_face(make_face(CMD_AVERAGE, 1, SMIN, SMIN, 0, 0, 0, 0));
		send_face(make_face(CMD_AVERAGE, 0, -32'sd3, 32'sd0, 0, 0, 5, 5));
		send_face(make_face(CMD_SPARE, 1, SMAX, SMIN, SMIN, SMAX, 0, CMAX));
		send_face(make_face(CMD_SPARE, 0, 32'sd7, 32'sd0, 1, 2, 3, 4));
		// Zero coefficients on either side of both pressure-based commands.
		send_face(make_face(CMD_RHIE_CHOW, 0, SMAX, 32'sd1, 5, 9, 0, 65536));
		send_face(make_face(CMD_RHIE_CHOW, 1, SMIN, SMIN, 5, 9, 65536, 0));
		send_face(make_face(CMD_CORRECT, 0, SMIN, 0, 5, 9, 0, 0));
		send_face(make_face(CMD_CORRECT, 1, SMAX, 0, SMAX, SMIN, 65536, 0));
		send_face(make_face(CMD_RHIE_CHOW, 0, 32'sh1_0000, 32'sh3_0000, 0, 32'sh1_0000,
			65536, 65536));
		send_face(make_face(CMD_CORRECT, 1, 32'sh1_0000, 0, 32'sh2_0000, 0, 65536, 131072));
		// Extreme differences over coefficient 1 saturate; CMAX cases follow.
		send_face(make_face(CMD_CORRECT, 0, SMAX, 0, SMAX, SMIN, 1, 1));
		send_face(make_face(CMD_CORRECT, 1, SMIN, 0, SMIN, SMAX, 1, 1));
		send_face(make_face(CMD_RHIE_CHOW, 0, SMAX, SMAX, SMIN, SMAX, 1, 1));
		send_face(make_face(CMD_RHIE_CHOW, 1, SMIN, SMIN, SMAX, SMIN, CMAX, CMAX));
		send_face(make_face(CMD_CORRECT, 0, SMIN, SMIN, SMAX, SMIN, CMAX, CMAX));
		f = make_face(CMD_RHIE_CHOW, 1, SMIN, SMAX, 0, 0, 1, CMAX);
		f.pb = SMAX; f.pm = SMIN; f.pf = SMAX;
		send_face(f);
		f.op = CMD_RHIE_CHOW; f.orient = 0; f.pb = SMIN; f.pm = SMAX; f.pf = SMIN;
		send_face(f);
		f = make_face(CMD_CORRECT, 0, 32'sd0, 32'sd0, 32'sd1, 32'sd0, CMAX, 1);
		send_face(f);
	endtask

	task automatic run_random(int count);
		repeat (count) send_face(rand_face());
	endtask

	task automatic test_register_extremes();
		write_reg(CFG_TIME_STEP, 31'd0);
		run_random(40);
		write_reg(CFG_TIME_STEP, 31'h7FFF_FFFF);
		write_reg(CFG_CELL_WIDTH, 31'h7FFF_FFFF);
		write_reg(CFG_CELL_HEIGHT, 31'd0);
		run_random(60);
		write_reg(CFG_CELL_WIDTH, 31'd1);
		write_reg(CFG_CELL_HEIGHT, 31'h7FFF_FFFF);
		run_random(60);
		write_reg(CFG_TIME_STEP, 31'($urandom()));
		write_reg(CFG_CELL_WIDTH, 31'($urandom()) >> $urandom_range(0, 30));
		write_reg(CFG_CELL_HEIGHT, 31'($urandom()) >> $urandom_range(0, 30));
		run_random(60);
	endtask

	task automatic test_idle_phases();
		write_reg(CFG_TIME_STEP, 31'd32768);
		write_reg(CFG_CELL_WIDTH, 31'd65536);
		write_reg(CFG_CELL_HEIGHT, 31'd131072);
		send_idle_pct = 38; recv_stall_pct = 66;
		run_random(550);
		send_idle_pct = 66; recv_stall_pct = 38;
		run_random(550);
		send_idle_pct = 0; recv_stall_pct = 0;
		run_random(550);
	endtask

	// The sender holds off until the pipeline is empty, then resumes.
	task automatic test_pause_refill();
		send_idle_pct = 20; recv_stall_pct = 30;
		run_random(30);
		drain_results();
		run_random(30);
	endtask

	always @(posedge clk) begin
		if (arst_n) out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	always @(posedge clk) begin
		face_result_t exp_r;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_faces.size() == 0) begin
				$display("%0t: result with nothing expected: vel %h status %0d",
					$time, face_velocity, status);
				errors++;
			end else begin
				exp_r = pending_faces.pop_front();
				checked++;
				if (face_velocity !== exp_r.vel) begin
					$display("%0t: face_velocity expected %h actual %h",
						$time, exp_r.vel, face_velocity);
					errors++;
				end
				if (status !== exp_r.st) begin
					$display("%0t: status expected %0d actual %0d",
						$time, exp_r.st, status);
					errors++;
				end
			end
		end
	end

	// Counts cycles in which no transfer happens on either channel.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || !arst_n)
			quiet_cycles <= 0;
		else if (quiet_cycles >= WATCHDOG) begin
			$display("%0t: no transfer for %0d cycles", $time, WATCHDOG);
			$display("TEST FAILED");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_pause_refill();
		test_register_extremes();
		test_idle_phases();
		drain_results();
		repeat (LATENCY + 4) @(posedge clk);
		$display("Sent %0d faces over all commands, %0d register writes, %0d results checked.",
			sent, n_writes, checked);
		$display("Zero-coefficient results: %0d, saturated results: %0d.", n_zero, n_sat);
		if (errors == 0 && pending_faces.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
